// ----- rtl/smda_pkg.sv -----
// ----------------------------------------------------------------------------
// smda_pkg
// Shared types and constants for the signed multiply/divide ALU: operation
// codes, data width and the packed words on the input and output channels.
// ----------------------------------------------------------------------------
`default_nettype none

package smda_pkg;

    // Operand and result width.
    localparam int DATA_WIDTH = 32;
    // Iteration counter width: one step per operand bit.
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    // Operation codes.
    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_MOD = 3'd4;

    // Input word: operation and two's-complement operands.
    typedef struct packed {
        logic        [2:0]            func;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } t_alu_in;

    // Output word: wrapped result and the zero-divisor flag.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic                         divide_by_zero;
    } t_alu_out;

endpackage

`default_nettype wire

// ----- rtl/signed_integer_mul_div_alu.sv -----
// ----------------------------------------------------------------------------
// signed_integer_mul_div_alu
// Signed add, subtract, multiply (low half), truncating divide and modulo,
// built around one shared adder/subtractor stepped by a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Word
//  --------+---------------------------+---------------------------------------
//  input   | i_in_valid / o_in_ready   | i_in_data  (func, operand_a, operand_b)
//  output  | o_out_valid / i_out_ready | o_out_data (result, divide_by_zero)
//
// Add, subtract, unused codes and a zero divisor take one step to load and
// one to form the result. Multiply and divide take one shift-add or
// restoring subtract step per bit through the shared adder, plus load and
// sign fix-up. The output word sits in its own register, so a new word is
// accepted while the previous result waits. A stalled output holds the
// sequencer in the fix-up step. Reset is synchronous and clears the
// sequencer and valid flag.
`default_nettype none

module signed_integer_mul_div_alu (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire smda_pkg::t_alu_in i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output smda_pkg::t_alu_out     o_out_data
);
    import smda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIX  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [2:0]            r_func, n_func;
    logic [DATA_WIDTH-1:0] r_x, n_x;       // multiplicand or divisor magnitude
    logic [DATA_WIDTH-1:0] r_q, n_q;       // multiplier or dividend/quotient
    logic [DATA_WIDTH-1:0] r_rem, n_rem;   // accumulator or partial remainder
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_neg, n_neg;   // result needs negating
    logic                  r_dz, n_dz;
    logic                  r_out_valid, n_out_valid;
    t_alu_out              r_out, n_out;

    // Shared adder inputs.
    logic [DATA_WIDTH-1:0] add_p, add_s;
    logic                  add_sub;
    logic [DATA_WIDTH:0]   add_sum;

    logic [DATA_WIDTH-1:0] in_a, in_b, mag_a, mag_b, part_rem;
    logic                  sign_a, sign_b, out_free;

    assign in_a     = i_in_data.operand_a;
    assign in_b     = i_in_data.operand_b;
    assign sign_a   = in_a[DATA_WIDTH-1];
    assign sign_b   = in_b[DATA_WIDTH-1];
    assign mag_a    = sign_a ? (~in_a + 1'b1) : in_a;
    assign mag_b    = sign_b ? (~in_b + 1'b1) : in_b;
    assign part_rem = {r_rem[DATA_WIDTH-2:0], r_q[DATA_WIDTH-1]};
    assign out_free = !r_out_valid || i_out_ready;

    // The one adder/subtractor; the top bit is the carry out (no borrow).
    assign add_sum = {1'b0, add_p} + {1'b0, (add_sub ? ~add_s : add_s)}
                   + {{DATA_WIDTH{1'b0}}, add_sub};

    // Adder operand selection for the iteration and fix-up steps.
    always_comb begin
        add_p   = '0;
        add_s   = '0;
        add_sub = 1'b0;
        if (r_state == S_RUN) begin
            if (r_func == FUNC_MUL) begin
                add_p = r_rem;
                add_s = r_q[0] ? r_x : '0;
            end else begin
                add_p   = part_rem;
                add_s   = r_x;
                add_sub = 1'b1;
            end
        end else if (!r_dz) begin
            case (r_func)
                FUNC_ADD: begin
                    add_p = r_rem;
                    add_s = r_x;
                end
                FUNC_SUB: begin
                    add_p   = r_rem;
                    add_s   = r_x;
                    add_sub = 1'b1;
                end
                FUNC_MUL: begin
                    add_p = r_rem;
                end
                FUNC_DIV: begin
                    add_s   = r_q;
                    add_sub = r_neg;
                end
                FUNC_MOD: begin
                    add_s   = r_rem;
                    add_sub = r_neg;
                end
                default: begin
                    add_p = '0;
                end
            endcase
        end
    end

    // Sequencer and datapath next state.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_x         = r_x;
        n_q         = r_q;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_dz        = r_dz;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in_data.func;
                    n_cnt   = '0;
                    n_dz    = 1'b0;
                    n_neg   = 1'b0;
                    n_state = S_FIX;
                    case (i_in_data.func)
                        FUNC_MUL: begin
                            n_x     = in_a;
                            n_q     = in_b;
                            n_rem   = '0;
                            n_state = S_RUN;
                        end
                        FUNC_DIV, FUNC_MOD: begin
                            n_x   = mag_b;
                            n_q   = mag_a;
                            n_rem = '0;
                            n_neg = (i_in_data.func == FUNC_DIV) ? (sign_a ^ sign_b)
                                                                : sign_a;
                            if (in_b == '0) begin
                                n_dz = 1'b1;
                            end else begin
                                n_state = S_RUN;
                            end
                        end
                        default: begin
                            n_rem = in_a;
                            n_x   = in_b;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (r_func == FUNC_MUL) begin
                    n_rem = add_sum[DATA_WIDTH-1:0];
                    n_x   = {r_x[DATA_WIDTH-2:0], 1'b0};
                    n_q   = {1'b0, r_q[DATA_WIDTH-1:1]};
                end else begin
                    n_rem = add_sum[DATA_WIDTH] ? add_sum[DATA_WIDTH-1:0] : part_rem;
                    n_q   = {r_q[DATA_WIDTH-2:0], add_sum[DATA_WIDTH]};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // Hand the word over once the output register is free.
                if (out_free) begin
                    n_out.result         = add_sum[DATA_WIDTH-1:0];
                    n_out.divide_by_zero = r_dz;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_x    <= n_x;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_dz   <= n_dz;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
